FILE: design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg: shared definitions for the multichannel moving average
// Sizes, derived widths, controller state type and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Configuration
  localparam int CHANNELS    = 8;
  localparam int WINDOW      = 16;
  localparam int SAMPLE_BITS = 10;

  // Fixed field widths of the channels
  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 10;
  localparam int MEAN_W   = 10;

  // Derived widths
  localparam int SMP_W    = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int HELD_W   = $clog2(WINDOW + 1);
  localparam int SUM_W    = $clog2(WINDOW * ((1 << SMP_W) - 1) + 1);
  localparam int CNT_W    = $clog2(SUM_W);
  localparam int RAM_DEPTH = CHANNELS * WINDOW;
  localparam int RAM_AW   = $clog2(RAM_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } mma_state_t;

  typedef struct packed {
    logic capture;   // latch the accepted request
    logic update;    // write ring, update channel state, load divider
    logic div_step;  // one quotient bit
    logic load_out;  // move result into the output register
  } mma_cmd_t;

  typedef struct packed {
    logic bad_channel;  // channel outside the configured range
    logic div_last;     // final divide step this cycle
    logic out_busy;     // output register holds an untaken result
  } mma_status_t;

endpackage

FILE: design/mma_if.sv
// ----------------------------------------------------------------------------
// mma_in_if / mma_out_if: request and result channels
// Valid/ready channels carrying the sample request and the mean result.
// ----------------------------------------------------------------------------
interface mma_in_if import mma_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CHAN_W-1:0]   channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if import mma_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel_out;
  logic [MEAN_W-1:0] mean;
  logic              window_full;

  modport source (output valid, output channel_out, output mean, output window_full,
                  input ready);
  modport sink   (input valid, input channel_out, input mean, input window_full,
                  output ready);
endinterface

FILE: design/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl: request sequencer
// Steps one request through ring read, state update, divide and hand-off.
// ----------------------------------------------------------------------------
module mma_ctrl import mma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  mma_status_t status,
  output mma_cmd_t    cmd
);

  mma_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_READ;
        end
      end
      ST_READ: begin
        // skip the update for a channel outside the range
        state_nxt = status.bad_channel ? ST_DONE : ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_READ))
    else $error("accepted request did not start a ring read");

  a_bad_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ && status.bad_channel) |=> !cmd.update && !cmd.div_step)
    else $error("out-of-range channel entered update or divide");

endmodule

FILE: design/mma_dpath.sv
// ----------------------------------------------------------------------------
// mma_dpath: moving average datapath
// Per-channel sums and counters, sample ring, serial divider, output register.
// ----------------------------------------------------------------------------
module mma_dpath import mma_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CHAN_W-1:0]   in_channel,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  mma_cmd_t            cmd,
  output mma_status_t         status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAN_W-1:0]   out_channel_out,
  output logic [MEAN_W-1:0]   out_mean,
  output logic                out_window_full
);

  // captured request
  logic [CHAN_W-1:0] ch_r;
  logic [SMP_W-1:0]  sample_r;
  logic              bad_r;

  // per-channel state
  logic [SUM_W-1:0]  sum_r  [CHANNELS];
  logic [IDX_W-1:0]  widx_r [CHANNELS];
  logic [HELD_W-1:0] held_r [CHANNELS];
  logic              full_r [CHANNELS];

  // divider
  logic [SUM_W-1:0]  quot_r, quot_nxt;
  logic [HELD_W-1:0] rem_r, rem_nxt;
  logic [HELD_W-1:0] divisor_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              wfull_r;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] out_ch_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic              out_full_r;

  logic [CH_W-1:0]   ch_idx;
  logic [IDX_W-1:0]  idx_cur, idx_nxt;
  logic [HELD_W-1:0] held_cur, held_nxt;
  logic              filled;
  logic [SUM_W-1:0]  sum_nxt;
  logic [RAM_AW-1:0] ram_addr;
  logic [SMP_W-1:0]  oldest;
  logic [HELD_W:0]   trial;
  logic              qbit;

  assign ch_idx   = CH_W'(ch_r);
  assign idx_cur  = widx_r[ch_idx];
  assign held_cur = held_r[ch_idx];
  assign filled   = (held_cur == HELD_W'(WINDOW));
  assign idx_nxt  = (idx_cur == IDX_W'(WINDOW - 1)) ? '0 : idx_cur + 1'b1;
  assign held_nxt = filled ? held_cur : held_cur + 1'b1;
  assign sum_nxt  = sum_r[ch_idx] - (filled ? SUM_W'(oldest) : '0) + SUM_W'(sample_r);
  assign ram_addr = RAM_AW'(ch_idx) * RAM_AW'(WINDOW) + RAM_AW'(idx_cur);

  mma_ram #(.WIDTH(SMP_W), .DEPTH(RAM_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.update),
    .waddr (ram_addr),
    .wdata (sample_r),
    .raddr (ram_addr),
    .rdata (oldest)
  );

  // restoring divide step: bring down the next dividend bit
  assign trial    = {rem_r, quot_r[SUM_W-1]};
  assign qbit     = (trial >= {1'b0, divisor_r});
  assign rem_nxt  = qbit ? HELD_W'(trial - {1'b0, divisor_r}) : HELD_W'(trial);
  assign quot_nxt = {quot_r[SUM_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r     <= in_channel;
      sample_r <= in_sample[SMP_W-1:0];
      bad_r    <= (32'(in_channel) >= CHANNELS);
    end
    if (cmd.update) begin
      quot_r    <= sum_nxt;
      rem_r     <= '0;
      divisor_r <= held_nxt;
      wfull_r   <= full_r[ch_idx] | filled;
    end else if (cmd.div_step) begin
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
    if (cmd.load_out) begin
      out_ch_r   <= ch_r;
      out_mean_r <= bad_r ? '0 : MEAN_W'(quot_r[SMP_W-1:0]);
      out_full_r <= bad_r ? 1'b0 : wfull_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        widx_r[i] <= '0;
        held_r[i] <= '0;
        full_r[i] <= 1'b0;
      end
    end else if (cmd.update) begin
      sum_r[ch_idx]  <= sum_nxt;
      widx_r[ch_idx] <= idx_nxt;
      held_r[ch_idx] <= held_nxt;
      full_r[ch_idx] <= full_r[ch_idx] | filled;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.update) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.bad_channel = bad_r;
  assign status.div_last    = (cnt_r == CNT_W'(SUM_W - 1));
  assign status.out_busy    = out_valid_r & ~out_ready;

  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_mean        = out_mean_r;
  assign out_window_full = out_full_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (divisor_r != '0))
    else $error("divide step with zero divisor");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !bad_r) |-> (held_cur <= HELD_W'(WINDOW)))
    else $error("sample count exceeds the window");

endmodule

FILE: design/multichannel_moving_average_core.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average_core: per-channel moving average of samples
// Top level joining the request sequencer and the averaging datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on in_stream carries a channel number and a raw converter
//   sample. Every request produces exactly one result on out_stream: the
//   channel, the truncated mean of the samples held for that channel (up to
//   WINDOW of them), and a flag that is set once the window has wrapped.
//   Both channels are valid/ready; a request moves on valid and ready high.
//
// Sequence:
//   A request goes from accept to its result on out_stream through the ring
//   read, the state update, the bit-serial divider and the hand-off. A new
//   request is taken only once the previous one has been handed off and the
//   sequencer is back in idle.
//
// Reset and stalls:
//   Reset (rst_n low, synchronous) clears all sums, counters, write indexes
//   and full flags; the sample ring needs no clearing since an entry is used
//   only after it has been written. A stalled receiver holds the result in
//   the output register while the next request is taken and processed; that
//   request then waits in its last step until the register frees up.
// ----------------------------------------------------------------------------
module multichannel_moving_average_core import mma_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mma_in_if.sink     in_stream,
  mma_out_if.source  out_stream
);

  mma_cmd_t    cmd;
  mma_status_t status;

  // sequence each request: read ring, update, divide, hand off
  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_ready (in_stream.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // hold channel state, the sample ring, the divider and the output register
  mma_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_channel      (in_stream.channel),
    .in_sample       (in_stream.sample),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_stream.valid),
    .out_ready       (out_stream.ready),
    .out_channel_out (out_stream.channel_out),
    .out_mean        (out_stream.mean),
    .out_window_full (out_stream.window_full)
  );

endmodule
